@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define LFSP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define LFSP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define LFSP_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define LFSP_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ hw/rtl/lfsp_pkg.sv @@
package lfsp_pkg;

   // fixed field widths
   localparam int WORD_BITS    = 32;
   localparam int CMD_BITS     = 3;
   localparam int POS_BITS     = 5;
   localparam int COUNT_BITS   = 5;
   localparam int STATUS_BITS  = 2;
   localparam int CAP_BITS     = 5;
   localparam int DEFAULT_DEPTH = 16;

   localparam logic [CAP_BITS-1:0]  CAP_RESET = 5'd16;
   localparam logic [WORD_BITS-1:0] FAIL_WORD = '1;

   // command codes
   localparam logic [CMD_BITS-1:0] CMD_PUSH   = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_POP    = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_PEEK   = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_TOP    = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_BOTTOM = 3'd4;

   // status codes
   localparam logic [STATUS_BITS-1:0] STAT_OK     = 2'd0;
   localparam logic [STATUS_BITS-1:0] STAT_OVER   = 2'd1;
   localparam logic [STATUS_BITS-1:0] STAT_UNDER  = 2'd2;
   localparam logic [STATUS_BITS-1:0] STAT_BADPOS = 2'd3;

   // register index of capacity
   localparam logic REG_CAPACITY = 1'b0;

   // per-cycle shift controls broadcast to every cell
   typedef struct packed {
      logic push;   // entries move one cell toward the bottom
      logic pop;    // entries move one cell toward the top
      logic snap;   // read chain captures the entries
      logic scan;   // read chain moves one cell toward the top
   } lfsp_shift_type;

endpackage

@@ hw/rtl/lfsp_ifs.sv @@
// request channel
interface lfsp_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  command;
   logic [31:0] push_value;
   logic [4:0]  position;

   modport source (output valid, command, push_value, position, input ready);
   modport sink   (input valid, command, push_value, position, output ready);
endinterface

// response channel
interface lfsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;
   logic [1:0]  status;
   logic [4:0]  entry_count;
   logic        is_full;
   logic        is_empty;

   modport source (output valid, read_data, status, entry_count, is_full, is_empty,
                   input ready);
   modport sink   (input valid, read_data, status, entry_count, is_full, is_empty,
                   output ready);
endinterface

@@ hw/rtl/lfsp_cell.sv @@
module lfsp_cell
   import lfsp_pkg::*;
(
   input  logic                 clock,
   input  lfsp_shift_type       shift,
   input  logic [WORD_BITS-1:0] from_above,
   input  logic [WORD_BITS-1:0] from_below,
   input  logic [WORD_BITS-1:0] chain_below,
   output logic [WORD_BITS-1:0] entry,
   output logic [WORD_BITS-1:0] chain
);

   logic [WORD_BITS-1:0] entry_ff;
   logic [WORD_BITS-1:0] chain_ff;

   // stack entry held by this cell
   always_ff @(posedge clock) begin
      if (shift.push) begin
         entry_ff <= from_above;
      end else if (shift.pop) begin
         entry_ff <= from_below;
      end
   end

   // read chain: snapshot, then walk toward the top one cell a cycle
   always_ff @(posedge clock) begin
      if (shift.snap) begin
         chain_ff <= entry_ff;
      end else if (shift.scan) begin
         chain_ff <= chain_below;
      end
   end

   assign entry = entry_ff;
   assign chain = chain_ff;

endmodule

@@ hw/rtl/lfsp_csr.sv @@
module lfsp_csr
   import lfsp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready,
   output logic [CAP_BITS-1:0] capacity
);

   logic [CAP_BITS-1:0] cap_ff;
   logic                wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == REG_CAPACITY);

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (wr_en) begin
         cap_ff <= csr_pwdata[CAP_BITS-1:0];
      end
   end

   // read back
   always_comb begin
      if (csr_paddr[2] == REG_CAPACITY) begin
         csr_prdata = 32'(cap_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   assign capacity = cap_ff;

endmodule

@@ hw/rtl/lifo_stack_with_peek_core.sv @@
// push, pop, top read, spare codes and every rejected command: the response goes to the result stage,
// then the output register; a peek at position p snapshots the read chain, which walks p - 1 cells,
// and a bottom read walks count - 1 cells before the result stage; no transfer is taken during the walk,
// and the result stage must empty before the next transfer
// output register holds one waiting response; a second finished result blocks the input
// synchronous reset clears the count, capacity (to 16), and handshake state; entries are not cleared
`include "assert_macros.svh"

module lifo_stack_with_peek_core
   import lfsp_pkg::*;
#(
   parameter int DEPTH = DEFAULT_DEPTH
)
(
   input  logic        clock,
   input  logic        reset,
   lfsp_req_if.sink    req,
   lfsp_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_BITS) ? CNT_W : POS_BITS;

   typedef enum logic {ST_IDLE, ST_SCAN} state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        fill_ff, fill_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;

   logic                    res_valid_ff, res_valid_in;
   logic [WORD_BITS-1:0]    res_data_ff, res_data_in;
   logic [STATUS_BITS-1:0]  res_status_ff, res_status_in;
   logic [COUNT_BITS-1:0]   res_count_ff, res_count_in;
   logic                    res_full_ff, res_full_in;
   logic                    res_empty_ff, res_empty_in;

   logic                    out_valid_ff;
   logic [WORD_BITS-1:0]    out_data_ff;
   logic [STATUS_BITS-1:0]  out_status_ff;
   logic [COUNT_BITS-1:0]   out_count_ff;
   logic                    out_full_ff;
   logic                    out_empty_ff;

   logic [CAP_BITS-1:0]     capacity;
   logic [CMP_W-1:0]        cap_eff;
   logic [CMP_W-1:0]        fill_w;
   logic [CMP_W-1:0]        fill_in_w;
   logic [CMP_W-1:0]        pos_w;
   logic                    is_full_now;
   logic                    accept;
   logic                    push_ok;
   logic                    res_move;
   lfsp_shift_type          shift;

   logic [WORD_BITS-1:0]    entry [DEPTH];
   logic [WORD_BITS-1:0]    chain [DEPTH];

   // configuration register
   lfsp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .capacity    (capacity)
   );

   // capacity clamped to 1..DEPTH
   always_comb begin
      if (capacity == '0) begin
         cap_eff = CMP_W'(1);
      end else if (CMP_W'(capacity) > CMP_W'(DEPTH)) begin
         cap_eff = CMP_W'(DEPTH);
      end else begin
         cap_eff = CMP_W'(capacity);
      end
   end

   assign fill_w      = CMP_W'(fill_ff);
   assign fill_in_w   = CMP_W'(fill_in);
   assign pos_w       = CMP_W'(req.position);
   assign is_full_now = (fill_w >= cap_eff);

   assign req.ready = (state_ff == ST_IDLE) && !res_valid_ff;
   assign accept    = req.valid && req.ready;
   assign push_ok   = accept && (req.command == CMD_PUSH) && !is_full_now;
   assign res_move  = res_valid_ff && (!out_valid_ff || rsp.ready);

   // row of cells, top of stack in cell 0
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_BITS-1:0] above;
      logic [WORD_BITS-1:0] below;
      logic [WORD_BITS-1:0] chain_below;

      if (i == 0) begin : g_top
         assign above = req.push_value;
      end else begin : g_mid
         assign above = entry[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign below       = '0;
         assign chain_below = '0;
      end else begin : g_inner
         assign below       = entry[i+1];
         assign chain_below = chain[i+1];
      end

      lfsp_cell u_cell (
         .clock       (clock),
         .shift       (shift),
         .from_above  (above),
         .from_below  (below),
         .chain_below (chain_below),
         .entry       (entry[i]),
         .chain       (chain[i])
      );
   end

   // command decode and next state
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      cnt_in        = cnt_ff;
      shift         = '0;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      res_valid_in  = res_move ? 1'b0 : res_valid_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_valid_in  = 1'b1;
               res_data_in   = '0;
               res_status_in = STAT_OK;
               case (req.command)
                  CMD_PUSH: begin
                     if (is_full_now) begin
                        res_status_in = STAT_OVER;
                     end else begin
                        shift.push = 1'b1;
                        fill_in    = fill_ff + 1'b1;
                     end
                  end
                  CMD_POP: begin
                     if (fill_ff == '0) begin
                        res_status_in = STAT_UNDER;
                        res_data_in   = FAIL_WORD;
                     end else begin
                        shift.pop   = 1'b1;
                        fill_in     = fill_ff - 1'b1;
                        res_data_in = entry[0];
                     end
                  end
                  CMD_PEEK: begin
                     if (pos_w == '0 || pos_w > fill_w) begin
                        res_status_in = STAT_BADPOS;
                        res_data_in   = FAIL_WORD;
                     end else begin
                        shift.snap   = 1'b1;
                        cnt_in       = CNT_W'(pos_w - 1'b1);
                        state_in     = ST_SCAN;
                        res_valid_in = 1'b0;
                     end
                  end
                  CMD_TOP: begin
                     if (fill_ff == '0) begin
                        res_status_in = STAT_UNDER;
                        res_data_in   = FAIL_WORD;
                     end else begin
                        res_data_in = entry[0];
                     end
                  end
                  CMD_BOTTOM: begin
                     if (fill_ff == '0) begin
                        res_status_in = STAT_UNDER;
                        res_data_in   = FAIL_WORD;
                     end else begin
                        shift.snap   = 1'b1;
                        cnt_in       = fill_ff - 1'b1;
                        state_in     = ST_SCAN;
                        res_valid_in = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (cnt_ff == '0) begin
               res_valid_in  = 1'b1;
               res_data_in   = chain[0];
               res_status_in = STAT_OK;
               state_in      = ST_IDLE;
            end else begin
               shift.scan = 1'b1;
               cnt_in     = cnt_ff - 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      res_count_in = COUNT_BITS'(fill_in);
      res_full_in  = (fill_in_w >= cap_eff);
      res_empty_in = (fill_in == '0);
   end

   // state, result stage and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         cnt_ff       <= '0;
         res_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         cnt_ff       <= cnt_in;
         res_valid_ff <= res_valid_in;
         if (res_move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (res_valid_in && !res_valid_ff) begin
         res_data_ff   <= res_data_in;
         res_status_ff <= res_status_in;
         res_count_ff  <= res_count_in;
         res_full_ff   <= res_full_in;
         res_empty_ff  <= res_empty_in;
      end
      if (res_move) begin
         out_data_ff   <= res_data_ff;
         out_status_ff <= res_status_ff;
         out_count_ff  <= res_count_ff;
         out_full_ff   <= res_full_ff;
         out_empty_ff  <= res_empty_ff;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.read_data   = out_data_ff;
   assign rsp.status      = out_status_ff;
   assign rsp.entry_count = out_count_ff;
   assign rsp.is_full     = out_full_ff;
   assign rsp.is_empty    = out_empty_ff;

   // checks
   `LFSP_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, fill_w <= CMP_W'(DEPTH))
   `LFSP_ASSERT_NEXT(a_push_grows, clock, reset, push_ok, fill_ff == $past(fill_ff) + 1'b1)
   `LFSP_ASSERT_NEXT(a_scan_frozen, clock, reset, state_ff == ST_SCAN, $stable(fill_ff))
   `LFSP_ASSERT_NOW(a_empty_flag, clock, reset, rsp.valid, rsp.is_empty == (rsp.entry_count == '0))

endmodule

@@ tb/lfsp_stack_checker.sv @@
`timescale 1ns / 100ps

// watches the request, response and csr traffic, predicts every response and compares
module lfsp_stack_checker
   import lfsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   lfsp_req_if         req_mon,
   lfsp_rsp_if         rsp_mon,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          error_count,
   output int          outstanding
);

   localparam int STACK_DEPTH = DEFAULT_DEPTH;

   typedef struct packed {
      logic [WORD_BITS-1:0]   data;
      logic [STATUS_BITS-1:0] status;
      logic [COUNT_BITS-1:0]  count;
      logic                   full;
      logic                   empty;
   } stack_result_type;

   // shadow of the stack contents and settings
   logic [WORD_BITS-1:0] word_store [STACK_DEPTH];
   int unsigned          fill_level;
   logic [CAP_BITS-1:0]  capacity_reg;
   stack_result_type     expected_results [$];

   initial begin
      error_count  = 0;
      outstanding  = 0;
      fill_level   = 0;
      capacity_reg = CAP_RESET;
   end

   // capacity register clamped to 1..depth
   function automatic int unsigned effective_capacity();
      if (capacity_reg == '0) begin
         return 1;
      end
      if (capacity_reg > STACK_DEPTH) begin
         return STACK_DEPTH;
      end
      return capacity_reg;
   endfunction

   // applies one command to the shadow stack and returns the response it should give
   function automatic stack_result_type run_command(input logic [CMD_BITS-1:0]  cmd,
                                                    input logic [WORD_BITS-1:0] value,
                                                    input logic [POS_BITS-1:0]  pos);
      stack_result_type res;
      int unsigned      cap_eff;
      cap_eff    = effective_capacity();
      res.data   = '0;
      res.status = STAT_OK;
      case (cmd)
         CMD_PUSH: begin
            // rejected push leaves the stack alone
            if (fill_level >= cap_eff) begin
               res.status = STAT_OVER;
            end else begin
               word_store[fill_level] = value;
               fill_level++;
            end
         end
         CMD_POP: begin
            if (fill_level == 0) begin
               res.status = STAT_UNDER;
               res.data   = FAIL_WORD;
            end else begin
               fill_level--;
               res.data = word_store[fill_level];
            end
         end
         CMD_PEEK: begin
            // position 1 is the top, zero and anything past the count are invalid
            if (pos == '0 || pos > fill_level) begin
               res.status = STAT_BADPOS;
               res.data   = FAIL_WORD;
            end else begin
               res.data = word_store[fill_level - pos];
            end
         end
         CMD_TOP: begin
            if (fill_level == 0) begin
               res.status = STAT_UNDER;
               res.data   = FAIL_WORD;
            end else begin
               res.data = word_store[fill_level - 1];
            end
         end
         CMD_BOTTOM: begin
            if (fill_level == 0) begin
               res.status = STAT_UNDER;
               res.data   = FAIL_WORD;
            end else begin
               res.data = word_store[0];
            end
         end
         default: begin
            // spare codes: no change, ok status, zero data
         end
      endcase
      res.count = COUNT_BITS'(fill_level);
      res.full  = (fill_level >= cap_eff);
      res.empty = (fill_level == 0);
      return res;
   endfunction

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t ns: %s mismatch, expected 0x%08h, got 0x%08h",
                  $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : track
      stack_result_type want;
      if (reset) begin
         fill_level   = 0;
         capacity_reg = CAP_RESET;
         expected_results.delete();
      end else begin
         // register write at the access phase
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[2] == REG_CAPACITY) begin
            capacity_reg = csr_pwdata[CAP_BITS-1:0];
         end

         // response transfer checked against the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               error_count++;
               $display("%0t ns: response mismatch, expected none, got data 0x%08h status %0d",
                        $time, rsp_mon.read_data, rsp_mon.status);
            end else begin
               want = expected_results.pop_front();
               compare_field("read_data", want.data, rsp_mon.read_data);
               compare_field("status", 32'(want.status), 32'(rsp_mon.status));
               compare_field("entry_count", 32'(want.count), 32'(rsp_mon.entry_count));
               compare_field("is_full", 32'(want.full), 32'(rsp_mon.is_full));
               compare_field("is_empty", 32'(want.empty), 32'(rsp_mon.is_empty));
            end
         end

         // request transfer updates the shadow stack
         if (req_mon.valid && req_mon.ready) begin
            expected_results.push_back(run_command(req_mon.command, req_mon.push_value,
                                                   req_mon.position));
         end
      end
      outstanding = expected_results.size();
   end

endmodule

@@ tb/tb_lifo_stack_with_peek_core.sv @@
`timescale 1ns / 100ps

module tb_lifo_stack_with_peek_core;
   import lfsp_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_COUNT  = 10;
   localparam int PHASE_ITEMS  = 103;

   // spare command codes, accepted but ignored by the stack
   localparam logic [CMD_BITS-1:0] CMD_SPARE_5 = 3'd5;
   localparam logic [CMD_BITS-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_BITS-1:0] CMD_SPARE_7 = 3'd7;

   localparam logic [2:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};
   localparam logic [2:0] UNMAPPED_ADDR = 3'd4;

   typedef enum int {RX_ALWAYS, RX_COIN, RX_MOSTLY} rx_mode_type;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          error_count;
   int          outstanding;
   int          cycle_count;

   logic [31:0] phase_caps [PHASE_COUNT];
   int          phase_push [PHASE_COUNT];

   lfsp_req_if req_ch ();
   lfsp_rsp_if rsp_ch ();

   lifo_stack_with_peek_core dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   lfsp_stack_checker result_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // response side: segments of steady, random and mostly-ready acceptance,
   // with a long hold-off every seventh segment so the stack backs up
   initial begin : receiver
      int          seg_no;
      int          seg_len;
      rx_mode_type mode;
      seg_no = 0;
      rsp_ch.ready <= 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         seg_no++;
         if (seg_no % 7 == 0) begin
            rsp_ch.ready <= 1'b0;
            seg_len = $urandom_range(40, 90);
            repeat (seg_len) @(negedge clock);
         end else begin
            mode    = rx_mode_type'($urandom_range(0, 2));
            seg_len = $urandom_range(10, 60);
            repeat (seg_len) begin
               case (mode)
                  RX_ALWAYS: rsp_ch.ready <= 1'b1;
                  RX_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
                  default:   rsp_ch.ready <= ($urandom_range(0, 4) != 0);
               endcase
               @(negedge clock);
            end
         end
      end
   end

   // offer one command and hold it until the transfer
   task automatic offer_command(input logic [CMD_BITS-1:0]  cmd,
                                input logic [WORD_BITS-1:0] value,
                                input logic [POS_BITS-1:0]  pos);
      req_ch.command    <= cmd;
      req_ch.push_value <= value;
      req_ch.position   <= pos;
      req_ch.valid      <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic pause_sender(input int cycles);
      req_ch.valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // every response back before touching the register
   task automatic wait_idle();
      pause_sender(1);
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [2:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // push data leaning on the sign and all-ones corners
   function automatic logic [WORD_BITS-1:0] random_word();
      case ($urandom_range(0, 7))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return '1;
         3:       return '0;
         default: return $urandom;
      endcase
   endfunction

   // peek positions mostly near the top to keep the read chain short
   function automatic logic [POS_BITS-1:0] random_position();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         return '0;
      end
      if (pick < 80) begin
         return POS_BITS'($urandom_range(1, 6));
      end
      return POS_BITS'($urandom_range(0, 16));
   endfunction

   // random commands in bursts; push_pct steers toward filling or draining
   task automatic run_random_phase(input int count, input int push_pct);
      int                   burst_left;
      int                   pick;
      logic [CMD_BITS-1:0]  cmd;
      burst_left = $urandom_range(1, 12);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < push_pct) begin
            cmd = CMD_PUSH;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 35)      cmd = CMD_POP;
            else if (pick < 70) cmd = CMD_PEEK;
            else if (pick < 82) cmd = CMD_TOP;
            else if (pick < 94) cmd = CMD_BOTTOM;
            else                cmd = CMD_BITS'($urandom_range(CMD_SPARE_5, CMD_SPARE_7));
         end
         offer_command(cmd, random_word(), random_position());
         burst_left--;
         if (burst_left == 0) begin
            pause_sender($urandom_range(1, 8));
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
         end
      end
   endtask

   initial begin
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.command     <= CMD_PUSH;
      req_ch.push_value  <= '0;
      req_ch.position    <= '0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;

      // fill first, then shrink below the count, then the clamped corners
      phase_caps[0] = 32'd16;        phase_push[0] = 75;
      phase_caps[1] = 32'd3;         phase_push[1] = 40;
      phase_caps[2] = 32'd1;         phase_push[2] = 50;
      phase_caps[3] = 32'hFFFF_FFE0; phase_push[3] = 50;
      phase_caps[4] = 32'hFFFF_FFFF; phase_push[4] = 70;
      phase_caps[5] = 32'hFFFF_FFE5; phase_push[5] = 50;
      phase_caps[6] = 32'd16;        phase_push[6] = 80;
      phase_caps[7] = $urandom_range(2, 15);  phase_push[7] = 30;
      phase_caps[8] = $urandom_range(17, 31); phase_push[8] = 60;
      phase_caps[9] = 32'd16;        phase_push[9] = 20;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_csr(CAPACITY_ADDR, 32'd16);

      // empty stack: underflow on every read, invalid peek
      offer_command(CMD_POP, '0, '0);
      offer_command(CMD_TOP, '0, '0);
      offer_command(CMD_BOTTOM, '0, '0);
      offer_command(CMD_PEEK, '0, 5'd1);
      offer_command(CMD_PEEK, '0, 5'd0);
      // word extremes
      offer_command(CMD_PUSH, 32'h7FFF_FFFF, 5'd31);
      offer_command(CMD_PUSH, 32'h8000_0000, 5'd0);
      offer_command(CMD_PUSH, 32'hFFFF_FFFF, 5'd16);
      offer_command(CMD_PUSH, 32'h0000_0000, 5'd15);
      // peeks inside and past the count
      offer_command(CMD_PEEK, '0, 5'd0);
      offer_command(CMD_PEEK, '0, 5'd1);
      offer_command(CMD_PEEK, '0, 5'd4);
      offer_command(CMD_PEEK, '0, 5'd5);
      offer_command(CMD_PEEK, '0, 5'd16);
      offer_command(CMD_PEEK, '0, 5'd31);
      offer_command(CMD_TOP, '0, '0);
      offer_command(CMD_BOTTOM, '0, '0);
      // spare codes
      offer_command(CMD_SPARE_5, 32'h1234_5678, 5'd1);
      offer_command(CMD_SPARE_6, 32'hDEAD_BEEF, 5'd2);
      offer_command(CMD_SPARE_7, 32'hA5A5_A5A5, 5'd3);
      // drain and one pop too many
      repeat (5) offer_command(CMD_POP, '0, '0);

      // write to an unmapped address, must change nothing
      wait_idle();
      write_csr(UNMAPPED_ADDR, 32'h0000_0001);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_idle();
         write_csr(CAPACITY_ADDR, phase_caps[p]);
         run_random_phase(PHASE_ITEMS, phase_push[p]);
      end

      // drain and let any stray response show up
      pause_sender(1);
      while (outstanding != 0) @(negedge clock);
      repeat (40) @(negedge clock);

      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
